// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSVT_ASSERT_NOW(lbl, clk, rst_n, cond, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error("csv tokenizer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CSVT_ASSERT_NEXT(lbl, clk, rst_n, cond, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error("csv tokenizer assertion failed");

`endif

// ===== rtl/core/csvt_pkg.sv =====
`timescale 1ns / 1ps
package csvt_pkg;

	localparam logic [7:0] BYTE_CR       = 8'd13;
	localparam logic [7:0] BYTE_LF       = 8'd10;
	localparam logic [7:0] BYTE_NUL      = 8'd0;
	localparam logic [7:0] DELIM_RESET   = 8'd44;
	localparam logic [7:0] QUOTE_RESET   = 8'd34;

	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_DELIMITER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_QUOTE     = 2'd1;

	typedef enum logic [5:0] {
		PH_START      = 6'b000001,
		PH_UNQUOTED   = 6'b000010,
		PH_QUOTED     = 6'b000100,
		PH_QUOTE_SEEN = 6'b001000,
		PH_AFTER      = 6'b010000,
		PH_AFTER_CR   = 6'b100000
	} phase_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] content_byte;
		logic       field_end;
		logic       ends_line;
		logic       was_quoted;
	} result_t;

endpackage

// ===== rtl/core/csvt_step.sv =====
`timescale 1ns / 1ps
// Next-phase and result logic for one text byte.
module csvt_step (
	input  csvt_pkg::phase_t  phase,
	input  logic [7:0]        text_byte,
	input  logic              end_of_text,
	input  logic [7:0]        delimiter_char,
	input  logic [7:0]        quote_char,
	output csvt_pkg::phase_t  next_phase,
	output csvt_pkg::result_t result
);
	import csvt_pkg::*;

	logic   eot;
	logic   is_quote;
	logic   is_delim;
	logic   is_cr;
	logic   is_lf;
	logic   sep_hit;
	phase_t sep_next;

	assign eot      = end_of_text || (text_byte == BYTE_NUL);
	assign is_quote = (text_byte == quote_char);
	assign is_delim = (text_byte == delimiter_char);
	assign is_cr    = (text_byte == BYTE_CR);
	assign is_lf    = (text_byte == BYTE_LF);
	assign sep_hit  = is_delim || is_cr || is_lf;
	// The delimiter test comes first, so a delimiter that equals CR does not end the line.
	assign sep_next = (!is_delim && is_cr) ? PH_AFTER_CR : PH_START;

	always_comb begin
		next_phase = phase;
		result     = '0;
		if (eot) begin
			next_phase = PH_START;
			case (phase)
				PH_UNQUOTED: begin
					result.valid     = 1'b1;
					result.field_end = 1'b1;
					result.ends_line = 1'b1;
				end
				PH_QUOTED, PH_QUOTE_SEEN, PH_AFTER: begin
					result.valid      = 1'b1;
					result.field_end  = 1'b1;
					result.ends_line  = 1'b1;
					result.was_quoted = 1'b1;
				end
				default: begin
					result.valid = 1'b0;
				end
			endcase
		end else begin
			case (phase)
				PH_UNQUOTED: begin
					result.valid = 1'b1;
					if (sep_hit) begin
						next_phase       = sep_next;
						result.field_end = 1'b1;
						result.ends_line = !is_delim;
					end else begin
						result.content_byte = text_byte;
					end
				end
				PH_QUOTED: begin
					if (is_quote) begin
						next_phase = PH_QUOTE_SEEN;
					end else begin
						result.valid        = 1'b1;
						result.content_byte = text_byte;
					end
				end
				PH_QUOTE_SEEN, PH_AFTER: begin
					if (phase == PH_QUOTE_SEEN && is_quote) begin
						next_phase          = PH_QUOTED;
						result.valid        = 1'b1;
						result.content_byte = text_byte;
					end else if (sep_hit) begin
						next_phase        = sep_next;
						result.valid      = 1'b1;
						result.field_end  = 1'b1;
						result.ends_line  = !is_delim;
						result.was_quoted = 1'b1;
					end else begin
						next_phase = PH_AFTER;
					end
				end
				default: begin
					// Field start; right after a CR a single LF is swallowed first.
					if (phase == PH_AFTER_CR && is_lf) begin
						next_phase = PH_START;
					end else if (is_quote) begin
						next_phase = PH_QUOTED;
					end else if (sep_hit) begin
						next_phase       = sep_next;
						result.valid     = 1'b1;
						result.field_end = 1'b1;
						result.ends_line = !is_delim;
					end else begin
						next_phase          = PH_UNQUOTED;
						result.valid        = 1'b1;
						result.content_byte = text_byte;
					end
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/csv_field_tokenizer.sv =====
`timescale 1ns / 1ps
// Channel  | Direction | Handshake            | Payload
// text in  | input     | in_valid / in_stall   | text_byte, end_of_text
// tokens   | output    | out_valid / out_stall | content_byte, field_end, ends_line, was_quoted
// config   | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One item is accepted per clock cycle while in_stall is low; its result, if it has one, is
// presented once it has passed from the input register through the phase logic into the
// result register.
// Reset clears the parse phase to field start and loads comma and double quote.
// A stalled result holds in the result register while one more item waits in the input
// register; only when both are full does in_stall rise. The config port is always ready and
// is written by the user only while the block is idle, which the block does not enforce.
module csv_field_tokenizer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [7:0]                        text_byte,
	input  logic                              end_of_text,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [7:0]                        content_byte,
	output logic                              field_end,
	output logic                              ends_line,
	output logic                              was_quoted,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [csvt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [7:0]                        cfg_data
);
	import csvt_pkg::*;

	`include "assert_macros.svh"

	// Configuration registers.
	logic [7:0] delimiter_q;
	logic [7:0] quote_q;

	// Input register: one item waiting for the phase logic.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eot_s1;

	// Parse phase; it advances when the item in the input register moves on.
	phase_t     phase_q;
	phase_t     step_next;
	result_t    step_res;

	// Result register.
	logic       out_valid_q;
	result_t    res_s2;

	logic       in_accept;
	logic       s2_load;
	logic       s1_move;

	assign cfg_ready = 1'b1;

	// The result register takes a new value when it is empty or being drained.
	assign s2_load   = !out_valid_q || !out_stall;
	assign s1_move   = valid_s1 && s2_load;
	assign in_stall  = valid_s1 && !s2_load;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delimiter_q <= DELIM_RESET;
			quote_q     <= QUOTE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DELIMITER: delimiter_q <= cfg_data;
				CFG_QUOTE:     quote_q     <= cfg_data;
				default: begin
					// Indexes past the register list are ignored.
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_s1 <= text_byte;
			eot_s1  <= end_of_text;
		end
	end

	csvt_step u_step (
		.phase          (phase_q),
		.text_byte      (byte_s1),
		.end_of_text    (eot_s1),
		.delimiter_char (delimiter_q),
		.quote_char     (quote_q),
		.next_phase     (step_next),
		.result         (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			out_valid_q <= 1'b0;
		end else if (s2_load) begin
			// An item that yields no result still consumes its slot and updates the phase.
			out_valid_q <= s1_move && step_res.valid;
			if (s1_move) begin
				phase_q <= step_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			res_s2 <= step_res;
		end
	end

	assign out_valid    = out_valid_q;
	assign content_byte = res_s2.content_byte;
	assign field_end    = res_s2.field_end;
	assign ends_line    = res_s2.ends_line;
	assign was_quoted   = res_s2.was_quoted;

	// A content result never carries field-end flags.
	`CSVT_ASSERT_NOW(a_content_flags, clk, arst_n, out_valid && !field_end, !ends_line && !was_quoted)
	// A field-end result carries a zero content byte.
	`CSVT_ASSERT_NOW(a_end_zero_byte, clk, arst_n, out_valid && field_end, content_byte == BYTE_NUL)
	// Entering the after-CR phase always comes with a line-ending field-end result.
	`CSVT_ASSERT_NEXT(a_cr_result, clk, arst_n, s1_move && step_next == PH_AFTER_CR,
		out_valid && field_end && ends_line)
	// Input is held back only while an item waits in the input register.
	`CSVT_ASSERT_NOW(a_stall_source, clk, arst_n, in_stall, valid_s1 && out_valid_q)

endmodule
